// ----- rtl/vfi_pkg.sv -----
// shared constants, codes and word types of the vertex-face incidence builder
package vfi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_FACES    = 2048;
    localparam int CORNERS      = 3;
    localparam int LIST_DEPTH   = CORNERS * MAX_FACES;

    // word field widths
    localparam int OP_W   = 3;
    localparam int VIDX_W = 10;
    localparam int POS_W  = 13;
    localparam int FACE_W = 11;
    localparam int CNT_W  = 13;
    localparam int VCNT_W = 11;
    localparam int ST_W   = 3;

    // internal widths
    localparam int VADDR_W  = $clog2(MAX_VERTICES);
    localparam int FADDR_W  = $clog2(MAX_FACES);
    localparam int LADDR_W  = $clog2(LIST_DEPTH);
    localparam int FTOT_W   = FADDR_W + 1;
    localparam int SWEEP_W  = VADDR_W + 1;
    localparam int KSEL_W   = 2;
    localparam int FREC_W   = CORNERS * VIDX_W;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_ADD     = 3'd1,
        OP_BUILD   = 3'd2,
        OP_QVERTEX = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_UNBUILT  = 3'd3,
        ST_POSITION = 3'd4
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [VIDX_W-1:0] corner_a;
        logic [VIDX_W-1:0] corner_b;
        logic [VIDX_W-1:0] corner_c;
        logic [VIDX_W-1:0] vertex_index;
        logic [POS_W-1:0]  entry_position;
    } req_word_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [FACE_W-1:0] face_number;
        logic [CNT_W-1:0]  incident_count;
        logic [CNT_W-1:0]  first_position;
    } rsp_word_t;

endpackage

// ----- rtl/vfi_if.sv -----
// valid/ready channel interfaces for request and response words
interface vfi_req_if import vfi_pkg::*;
    ;
    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vfi_rsp_if import vfi_pkg::*;
    ;
    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vfi_ram.sv -----
// generic single write port ram with registered read
module vfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vertex_face_incidence_builder.sv -----
// vertex-face incidence builder: sequencer, state memories and response register
//
// request channel (req): one word per operation - clear, add face, build,
// query vertex or read entry. response channel (rsp): exactly one word per
// request, in order. cfg_we / cfg_wdata set the live vertex count while idle;
// the user must keep to that, the block itself does not enforce it. one
// operation is in flight at a time; req.ready is high only while the
// sequencer is idle, and it stays high while a response waits in the output
// register. errors and unknown operations answer in the accept cycle, a
// vertex query or entry read in the cycle after (one ram read), an add after
// three read-modify-write passes on the tally ram. a build accepts, runs the
// prefix sum over the tally ram, scatters each stored face (face read, then
// three cursor read-modify-writes) and ends with a closing check.
// clear and reset both sweep the tally ram with req.ready low. if a result is
// ready while the output register holds a word and rsp.ready is low, it is held
// in a side register and the sequencer waits until the output register frees.
module vertex_face_incidence_builder import vfi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [VCNT_W-1:0]  cfg_wdata,
    vfi_req_if.sink            req,
    vfi_rsp_if.source          rsp
);

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_QVTX,
        S_QENT,
        S_ADD_RD,
        S_ADD_WR,
        S_SUM,
        S_FACE_RD,
        S_FACE_WAIT,
        S_SCAT_RD,
        S_SCAT_WR,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [VCNT_W-1:0]   vcount_reg, vcount_next;
    logic [FTOT_W-1:0]   face_total_reg, face_total_next;
    logic                built_reg, built_next;
    logic [POS_W-1:0]    list_total_reg, list_total_next;
    logic [SWEEP_W-1:0]  idx_reg, idx_next;
    logic [FTOT_W-1:0]   face_idx_reg, face_idx_next;
    logic [CNT_W-1:0]    sum_reg, sum_next;
    logic [KSEL_W-1:0]   k_reg, k_next;
    logic [VIDX_W-1:0]   corner_reg [CORNERS];
    logic [VIDX_W-1:0]   corner_next [CORNERS];
    logic [FACE_W-1:0]   fnum_reg, fnum_next;
    logic                wipe_reply_reg, wipe_reply_next;
    rsp_word_t           res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    rsp_word_t           out_data_reg, out_data_next;

    // memory ports
    logic                face_we;
    logic [FADDR_W-1:0]  face_waddr, face_raddr;
    logic [FREC_W-1:0]   face_wdata, face_rdata;
    logic                tally_we;
    logic [VADDR_W-1:0]  tally_waddr, tally_raddr;
    logic [CNT_W-1:0]    tally_wdata, tally_rdata;
    logic                offs_we;
    logic [VADDR_W-1:0]  offs_waddr, offs_raddr;
    logic [CNT_W-1:0]    offs_wdata, offs_rdata;
    logic                curs_we;
    logic [VADDR_W-1:0]  curs_waddr, curs_raddr;
    logic [POS_W-1:0]    curs_wdata, curs_rdata;
    logic                list_we;
    logic [LADDR_W-1:0]  list_waddr, list_raddr;
    logic [FACE_W-1:0]   list_wdata, list_rdata;

    logic                fin;
    rsp_word_t           fin_word;
    logic                out_free;
    logic [VCNT_W-1:0]   live;
    logic                corner_bad;
    logic [SWEEP_W-1:0]  idx_prev;
    logic                k_last;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign live      = (vcount_reg < VCNT_W'(MAX_VERTICES)) ? vcount_reg
                                                            : VCNT_W'(MAX_VERTICES);
    assign corner_bad = ({1'b0, req.data.corner_a} >= live)
                     || ({1'b0, req.data.corner_b} >= live)
                     || ({1'b0, req.data.corner_c} >= live);
    assign idx_prev  = idx_reg - SWEEP_W'(1);
    assign k_last    = (k_reg == KSEL_W'(CORNERS - 1));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = cfg_we ? cfg_wdata : vcount_reg;
        face_total_next = face_total_reg;
        built_next      = built_reg;
        list_total_next = list_total_reg;
        idx_next        = idx_reg;
        face_idx_next   = face_idx_reg;
        sum_next        = sum_reg;
        k_next          = k_reg;
        corner_next     = corner_reg;
        fnum_next       = fnum_reg;
        wipe_reply_next = wipe_reply_reg;
        res_next        = res_reg;
        fin             = 1'b0;
        fin_word        = '0;

        face_we     = 1'b0;
        face_waddr  = face_total_reg[FADDR_W-1:0];
        face_wdata  = {req.data.corner_c, req.data.corner_b, req.data.corner_a};
        face_raddr  = face_idx_reg[FADDR_W-1:0];
        tally_we    = 1'b0;
        tally_waddr = corner_reg[k_reg];
        tally_wdata = tally_rdata + CNT_W'(1);
        tally_raddr = corner_reg[k_reg];
        offs_we     = 1'b0;
        offs_waddr  = idx_prev[VADDR_W-1:0];
        offs_wdata  = sum_reg;
        offs_raddr  = req.data.vertex_index;
        curs_we     = 1'b0;
        curs_waddr  = corner_reg[k_reg];
        curs_wdata  = curs_rdata + POS_W'(1);
        curs_raddr  = corner_reg[k_reg];
        list_we     = 1'b0;
        list_waddr  = curs_rdata[LADDR_W-1:0];
        list_wdata  = face_idx_reg[FACE_W-1:0];
        list_raddr  = req.data.entry_position[LADDR_W-1:0];

        unique case (state_reg)
            S_WIPE:
            begin
                tally_we    = 1'b1;
                tally_waddr = idx_reg[VADDR_W-1:0];
                tally_wdata = '0;
                idx_next    = idx_reg + SWEEP_W'(1);
                if (idx_reg == SWEEP_W'(MAX_VERTICES - 1))
                begin
                    if (wipe_reply_reg)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                tally_raddr = req.data.vertex_index;
                if (req.valid)
                begin
                    unique case (op_t'(req.data.operation))
                        OP_CLEAR:
                        begin
                            face_total_next = '0;
                            built_next      = 1'b0;
                            idx_next        = '0;
                            wipe_reply_next = 1'b1;
                            state_next      = S_WIPE;
                        end
                        OP_ADD:
                        begin
                            if (corner_bad)
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_RANGE;
                            end
                            else if (face_total_reg >= FTOT_W'(MAX_FACES))
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_FULL;
                            end
                            else
                            begin
                                face_we         = 1'b1;
                                corner_next[0]  = req.data.corner_a;
                                corner_next[1]  = req.data.corner_b;
                                corner_next[2]  = req.data.corner_c;
                                k_next          = '0;
                                fnum_next       = face_total_reg[FACE_W-1:0];
                                face_total_next = face_total_reg + FTOT_W'(1);
                                built_next      = 1'b0;
                                state_next      = S_ADD_RD;
                            end
                        end
                        OP_BUILD:
                        begin
                            idx_next   = '0;
                            sum_next   = '0;
                            state_next = S_SUM;
                        end
                        OP_QVERTEX:
                        begin
                            if (!built_reg)
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_UNBUILT;
                            end
                            else if ({1'b0, req.data.vertex_index} >= live)
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_QVTX;
                            end
                        end
                        OP_READ:
                        begin
                            if (!built_reg)
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_UNBUILT;
                            end
                            else if ((req.data.entry_position >= list_total_reg)
                                  || (req.data.entry_position >= POS_W'(LIST_DEPTH)))
                            begin
                                fin             = 1'b1;
                                fin_word.status = ST_POSITION;
                            end
                            else
                            begin
                                state_next = S_QENT;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_QVTX:
            begin
                fin                     = 1'b1;
                fin_word.incident_count = tally_rdata;
                fin_word.first_position = offs_rdata;
            end
            S_QENT:
            begin
                fin                  = 1'b1;
                fin_word.face_number = list_rdata;
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                tally_we = 1'b1;
                k_next   = k_reg + KSEL_W'(1);
                if (k_last)
                begin
                    fin                  = 1'b1;
                    fin_word.face_number = fnum_reg;
                end
                else
                begin
                    state_next = S_ADD_RD;
                end
            end
            S_SUM:
            begin
                // read of slot idx issued, data of slot idx-1 arrives
                tally_raddr = idx_reg[VADDR_W-1:0];
                idx_next    = idx_reg + SWEEP_W'(1);
                if (idx_reg != '0)
                begin
                    offs_we    = 1'b1;
                    curs_we    = 1'b1;
                    curs_waddr = idx_prev[VADDR_W-1:0];
                    curs_wdata = sum_reg;
                    sum_next   = sum_reg + tally_rdata;
                end
                if (idx_reg == SWEEP_W'(MAX_VERTICES))
                begin
                    list_total_next = sum_reg + tally_rdata;
                    face_idx_next   = '0;
                    state_next      = S_FACE_RD;
                end
            end
            S_FACE_RD:
            begin
                if (face_idx_reg == face_total_reg)
                begin
                    built_next = 1'b1;
                    fin        = 1'b1;
                end
                else
                begin
                    state_next = S_FACE_WAIT;
                end
            end
            S_FACE_WAIT:
            begin
                for (int i = 0; i < CORNERS; i++)
                begin
                    corner_next[i] = face_rdata[i*VIDX_W +: VIDX_W];
                end
                k_next     = '0;
                state_next = S_SCAT_RD;
            end
            S_SCAT_RD:
            begin
                state_next = S_SCAT_WR;
            end
            S_SCAT_WR:
            begin
                if (curs_rdata < POS_W'(LIST_DEPTH))
                begin
                    list_we = 1'b1;
                    curs_we = 1'b1;
                end
                k_next = k_reg + KSEL_W'(1);
                if (k_last)
                begin
                    face_idx_next = face_idx_reg + FTOT_W'(1);
                    state_next    = S_FACE_RD;
                end
                else
                begin
                    state_next = S_SCAT_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        if (state_reg == S_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fin_word;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = fin_word;
                state_next = S_EMIT;
            end
            wipe_reply_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WIPE;
            vcount_reg     <= VCOUNT_RESET;
            face_total_reg <= '0;
            built_reg      <= 1'b0;
            list_total_reg <= '0;
            idx_reg        <= '0;
            face_idx_reg   <= '0;
            sum_reg        <= '0;
            k_reg          <= '0;
            for (int i = 0; i < CORNERS; i++)
            begin
                corner_reg[i] <= '0;
            end
            fnum_reg       <= '0;
            wipe_reply_reg <= 1'b0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            face_total_reg <= face_total_next;
            built_reg      <= built_next;
            list_total_reg <= list_total_next;
            idx_reg        <= idx_next;
            face_idx_reg   <= face_idx_next;
            sum_reg        <= sum_next;
            k_reg          <= k_next;
            corner_reg     <= corner_next;
            fnum_reg       <= fnum_next;
            wipe_reply_reg <= wipe_reply_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // stored triangles, one corner per slice
    vfi_ram #(.WIDTH(FREC_W), .DEPTH(MAX_FACES)) u_face_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (face_waddr),
        .wdata (face_wdata),
        .raddr (face_raddr),
        .rdata (face_rdata)
    );

    vfi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_tally_ram (
        .clk   (clk),
        .we    (tally_we),
        .waddr (tally_waddr),
        .wdata (tally_wdata),
        .raddr (tally_raddr),
        .rdata (tally_rdata)
    );

    vfi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_offset_ram (
        .clk   (clk),
        .we    (offs_we),
        .waddr (offs_waddr),
        .wdata (offs_wdata),
        .raddr (offs_raddr),
        .rdata (offs_rdata)
    );

    // fill cursors for the scatter pass
    vfi_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_cursor_ram (
        .clk   (clk),
        .we    (curs_we),
        .waddr (curs_waddr),
        .wdata (curs_wdata),
        .raddr (curs_raddr),
        .rdata (curs_rdata)
    );

    vfi_ram #(.WIDTH(FACE_W), .DEPTH(LIST_DEPTH)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

endmodule

// ----- bench/vfi_checker.sv -----
// checker for the incidence builder: predicts every response word and compares it
`timescale 1ns / 1ps

module vfi_checker
    import vfi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [VCNT_W-1:0] cfg_wdata,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_word_t         req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_word_t         rsp_data,
    output int unsigned       mismatch_count,
    output int unsigned       awaited_count,
    output int unsigned       checked_count
);

    // own copy of the table state
    logic [VIDX_W-1:0] mesh_faces [MAX_FACES][CORNERS];
    logic [FTOT_W-1:0] faces_held;
    logic [CNT_W-1:0]  tally [MAX_VERTICES];
    logic [CNT_W-1:0]  offsets [MAX_VERTICES+1];
    logic [CNT_W-1:0]  cursor [MAX_VERTICES];
    logic [FACE_W-1:0] incidence [LIST_DEPTH];
    logic              built;
    logic [VCNT_W-1:0] vertex_count;

    rsp_word_t   answers_due [$];
    rsp_word_t   want;
    int unsigned errors;
    int unsigned checked;

    task automatic empty_table();
        faces_held = '0;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            tally[v] = '0;
        end
        built = 1'b0;
    endtask

    // works out the one response word a request causes, updating the state
    task automatic incidence_answer(input req_word_t w, output rsp_word_t r);
        int unsigned       live;
        int unsigned       vtx;
        int unsigned       pos;
        logic [VIDX_W-1:0] corner [CORNERS];
        logic [VIDX_W-1:0] c;
        logic              bad;
        live = (vertex_count < MAX_VERTICES) ? vertex_count : MAX_VERTICES;
        corner[0] = w.corner_a;
        corner[1] = w.corner_b;
        corner[2] = w.corner_c;
        vtx = w.vertex_index;
        pos = w.entry_position;
        r = '0;
        r.status = ST_OK;
        case (w.operation)
            OP_CLEAR: empty_table();
            OP_ADD:
            begin
                bad = 1'b0;
                for (int k = 0; k < CORNERS; k++)
                begin
                    if (corner[k] >= live)
                        bad = 1'b1;
                end
                if (bad)
                    r.status = ST_RANGE;
                else if (faces_held >= MAX_FACES)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = 0; k < CORNERS; k++)
                    begin
                        mesh_faces[faces_held[FADDR_W-1:0]][k] = corner[k];
                        tally[corner[k]] = tally[corner[k]] + 1'b1;
                    end
                    r.face_number = faces_held[FACE_W-1:0];
                    faces_held = faces_held + 1'b1;
                    built = 1'b0;
                end
            end
            OP_BUILD:
            begin
                // prefix sum over every slot, then scatter faces in face order
                offsets[0] = '0;
                for (int v = 0; v < MAX_VERTICES; v++)
                begin
                    offsets[v+1] = offsets[v] + tally[v];
                    cursor[v] = offsets[v];
                end
                for (int f = 0; f < faces_held; f++)
                begin
                    for (int k = 0; k < CORNERS; k++)
                    begin
                        c = mesh_faces[f][k];
                        if (cursor[c] < LIST_DEPTH)
                        begin
                            incidence[cursor[c]] = FACE_W'(f);
                            cursor[c] = cursor[c] + 1'b1;
                        end
                    end
                end
                built = 1'b1;
            end
            OP_QVERTEX:
            begin
                if (!built)
                    r.status = ST_UNBUILT;
                else if (vtx >= live)
                    r.status = ST_RANGE;
                else
                begin
                    r.first_position = offsets[vtx];
                    r.incident_count = offsets[vtx+1] - offsets[vtx];
                end
            end
            OP_READ:
            begin
                if (!built)
                    r.status = ST_UNBUILT;
                else if (pos >= offsets[MAX_VERTICES] || pos >= LIST_DEPTH)
                    r.status = ST_POSITION;
                else
                    r.face_number = incidence[pos];
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_table();
            vertex_count = VCOUNT_RESET;
            answers_due.delete();
            errors = 0;
            checked = 0;
            mismatch_count <= 0;
            awaited_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_we)
                vertex_count = cfg_wdata;
            // a word answered at this edge belongs to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response word with no request waiting: %h", rsp_data);
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    checked++;
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        errors++;
                    end
                    if (rsp_data.face_number !== want.face_number)
                    begin
                        $error("face_number: expected %0d, got %0d",
                               want.face_number, rsp_data.face_number);
                        errors++;
                    end
                    if (rsp_data.incident_count !== want.incident_count)
                    begin
                        $error("incident_count: expected %0d, got %0d",
                               want.incident_count, rsp_data.incident_count);
                        errors++;
                    end
                    if (rsp_data.first_position !== want.first_position)
                    begin
                        $error("first_position: expected %0d, got %0d",
                               want.first_position, rsp_data.first_position);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                incidence_answer(req_data, want);
                answers_due.push_back(want);
            end
            mismatch_count <= errors;
            awaited_count <= answers_due.size();
            checked_count <= checked;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// top of the incidence builder bench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
    import vfi_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int PHASES         = 8;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [VCNT_W-1:0] cfg_wdata;

    vfi_req_if req_ch();
    vfi_rsp_if rsp_ch();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;

    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 83;
    int unsigned live_vertices = MAX_VERTICES;
    int unsigned listed_faces  = 0;
    int unsigned words_sent    = 0;
    int unsigned random_sent   = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;

    vertex_face_incidence_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    vfi_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_valid      (req_ch.valid),
        .req_ready      (req_ch.ready),
        .req_data       (req_ch.data),
        .rsp_valid      (rsp_ch.valid),
        .rsp_ready      (rsp_ch.ready),
        .rsp_data       (rsp_ch.data),
        .mismatch_count (mismatches),
        .awaited_count  (outstanding),
        .checked_count  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic req_word_t random_word();
        req_word_t w;
        w.operation      = OP_W'($urandom);
        w.corner_a       = VIDX_W'($urandom);
        w.corner_b       = VIDX_W'($urandom);
        w.corner_c       = VIDX_W'($urandom);
        w.vertex_index   = VIDX_W'($urandom);
        w.entry_position = POS_W'($urandom);
        return w;
    endfunction

    // mostly a legal vertex, now and then the top one or any index at all
    function automatic logic [VIDX_W-1:0] pick_vertex();
        int unsigned roll;
        roll = $urandom_range(99);
        if (live_vertices == 0 || roll < 8)
            return VIDX_W'($urandom);
        if (roll < 14)
            return VIDX_W'(live_vertices - 1);
        return VIDX_W'($urandom_range(live_vertices - 1));
    endfunction

    task automatic send_word(input req_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        words_sent++;
        // rough list length, only to steer read positions
        if (w.operation == OP_CLEAR)
            listed_faces = 0;
        else if (w.operation == OP_ADD && w.corner_a < live_vertices
                 && w.corner_b < live_vertices && w.corner_c < live_vertices
                 && listed_faces < MAX_FACES)
            listed_faces++;
    endtask

    task automatic send_op(input op_t op, input int unsigned a, input int unsigned b,
                           input int unsigned c, input int unsigned vtx,
                           input int unsigned pos);
        req_word_t w;
        w = random_word();
        w.operation      = op;
        w.corner_a       = VIDX_W'(a);
        w.corner_b       = VIDX_W'(b);
        w.corner_c       = VIDX_W'(c);
        w.vertex_index   = VIDX_W'(vtx);
        w.entry_position = POS_W'(pos);
        send_word(w);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_vertex_count(input int unsigned vc);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= VCNT_W'(vc);
        @(posedge clk);
        cfg_we    <= 1'b0;
        live_vertices = (vc < MAX_VERTICES) ? vc : MAX_VERTICES;
        settings_used++;
    endtask

    // mostly add-build-query runs with random content, some plain noise
    task automatic random_sequence();
        req_word_t   w;
        int unsigned span;
        if ($urandom_range(99) < 80)
        begin
            if ($urandom_range(1))
            begin
                w = random_word();
                w.operation = OP_CLEAR;
                send_word(w);
                random_sent++;
            end
            repeat ($urandom_range(12, 1))
            begin
                w = random_word();
                w.operation = OP_ADD;
                w.corner_a  = pick_vertex();
                w.corner_b  = pick_vertex();
                w.corner_c  = pick_vertex();
                send_word(w);
                random_sent++;
            end
            w = random_word();
            w.operation = OP_BUILD;
            send_word(w);
            random_sent++;
            repeat ($urandom_range(10, 3))
            begin
                w = random_word();
                span = CORNERS * listed_faces;
                if ($urandom_range(1))
                begin
                    w.operation    = OP_QVERTEX;
                    w.vertex_index = pick_vertex();
                end
                else
                begin
                    w.operation = OP_READ;
                    if (span != 0 && $urandom_range(99) < 85)
                        w.entry_position = POS_W'($urandom_range(span - 1));
                    else if ($urandom_range(1))
                        w.entry_position = POS_W'(span);
                end
                send_word(w);
                random_sent++;
            end
        end
        else
        begin
            repeat ($urandom_range(6, 1))
            begin
                send_word(random_word());
                random_sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned plan [PHASES];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // queries on a table never built, then an empty build
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 1023, 0);
        send_op(OP_BUILD, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 0, 0);
        // corner extremes and a face that repeats a vertex
        send_op(OP_ADD, 0, 0, 0, 0, 0);
        send_op(OP_ADD, 1023, 1023, 1023, 0, 0);
        send_op(OP_ADD, 0, 1023, 512, 0, 0);
        send_op(OP_BUILD, 0, 0, 0, 0, 0);
        send_op(OP_ADD, 5, 5, 7, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 5, 0);
        send_op(OP_BUILD, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 5, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 1023, 0);
        send_op(OP_READ, 0, 0, 0, 0, 5);
        send_op(OP_READ, 0, 0, 0, 0, 11);
        send_op(OP_READ, 0, 0, 0, 0, 12);
        send_op(OP_READ, 0, 0, 0, 0, 8191);
        send_op(op_t'(7), 1023, 1023, 1023, 1023, 8191);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 0, 0);

        // smallest vertex count: range errors and their priority
        set_vertex_count(1);
        send_op(OP_ADD, 0, 0, 0, 0, 0);
        send_op(OP_ADD, 0, 0, 1, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 1, 0);
        send_op(OP_BUILD, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 1, 0);
        // zero count keeps the built table but rejects every vertex
        set_vertex_count(0);
        send_op(OP_ADD, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 2);

        plan[0] = MAX_VERTICES;
        plan[1] = 1;
        plan[2] = (1 << VCNT_W) - 1;
        plan[3] = 0;
        plan[4] = $urandom_range(MAX_VERTICES - 1, 2);
        plan[5] = $urandom_range((1 << VCNT_W) - 2, MAX_VERTICES + 1);
        plan[6] = 4;
        plan[7] = MAX_VERTICES - 1;
        for (int p = 0; p < PHASES; p++)
        begin
            set_vertex_count(plan[p]);
            while (random_sent < (p + 1) * RANDOM_ITEMS / PHASES)
            begin
                if (random_sent >= 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else if (random_sent >= RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 17;
                end
                random_sequence();
            end
        end

        // fill the store with one vertex, then overflow it
        set_vertex_count(1000);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);
        repeat (MAX_FACES)
            send_op(OP_ADD, 0, 0, 0, 0, 0);
        send_op(OP_ADD, 0, 0, 0, 0, 0);
        send_op(OP_ADD, 1000, 0, 0, 0, 0);
        send_op(OP_BUILD, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 0, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 999, 0);
        send_op(OP_QVERTEX, 0, 0, 0, 1000, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, LIST_DEPTH - 1);
        send_op(OP_READ, 0, 0, 0, 0, LIST_DEPTH);
        send_op(OP_READ, 0, 0, 0, 0, 8191);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d random) under %0d vertex-count settings",
                 words_sent, random_sent, settings_used + 1);
        $display("%0d response words checked, incidence store filled to capacity once",
                 checked);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- vertex_face_incidence_builder.f -----
rtl/vfi_pkg.sv
rtl/vfi_if.sv
rtl/vfi_ram.sv
rtl/vertex_face_incidence_builder.sv
bench/vfi_checker.sv
bench/testbench.sv
